/* hw/rtl/icm_pkg.sv */
// Shared types, constants and helper functions of the IR frame code matcher.
// Used by icm_ctrl, icm_dp and the top level; depends on nothing.
package icm_pkg;

  localparam int unsigned TableDepth     = 256;
  localparam logic [31:0] RepeatWindowUs = 32'd1000000;
  localparam logic [2:0]  PhaseWrap      = 3'd4;
  localparam logic [1:0]  PhaseRestart   = 2'd2;

  localparam logic [1:0] StatusLoad = 2'd0;
  localparam logic [1:0] StatusKey  = 2'd1;
  localparam logic [1:0] StatusMiss = 2'd2;
  localparam logic [1:0] StatusHeld = 2'd3;

  localparam logic        OpLoad   = 1'b0;
  localparam logic        OpDecode = 1'b1;

  localparam logic [2:0] RegPreBits  = 3'd0;
  localparam logic [2:0] RegKeyBits  = 3'd1;
  localparam logic [2:0] RegPostBits = 3'd2;
  localparam logic [2:0] RegPrefix   = 3'd3;
  localparam logic [2:0] RegSuffix   = 3'd4;
  localparam logic [2:0] RegTogPos   = 3'd5;
  localparam logic [2:0] RegXorMask  = 3'd6;
  localparam logic [2:0] RegReverse  = 3'd7;

  typedef struct packed {
    logic [5:0]  pre_bits;
    logic [6:0]  key_bits;
    logic [5:0]  post_bits;
    logic [31:0] prefix;
    logic [31:0] suffix;
    logic [6:0]  tog_pos;
    logic [63:0] xor_mask;
    logic        reverse;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic prep;
    logic scan_start;
    logic scan_step;
    logic finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic pre_ok;
    logic hit;
    logic last;
  } stat_t;

  function automatic logic [63:0] low_mask(input logic [7:0] n);
    logic [63:0] m;
    m = (n >= 8'd64) ? '1 : ((64'd1 << n[5:0]) - 64'd1);
    return m;
  endfunction

  function automatic logic [63:0] shl64(input logic [63:0] x, input logic [7:0] n);
    logic [63:0] r;
    r = (n >= 8'd64) ? 64'd0 : (x << n[5:0]);
    return r;
  endfunction

  function automatic logic [63:0] shr64(input logic [63:0] x, input logic [7:0] n);
    logic [63:0] r;
    r = (n >= 8'd64) ? 64'd0 : (x >> n[5:0]);
    return r;
  endfunction

  function automatic logic [63:0] bitrev64(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) begin
      r[i] = x[63-i];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/icm_if.sv */
// Valid/ready channel interfaces for frame/load items and result items.
// Depends on nothing.
interface icm_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  entry_index;
  logic [63:0] entry_code;
  logic        entry_valid;
  logic [31:0] frame_prefix;
  logic [63:0] frame_key;
  logic [31:0] frame_suffix;
  logic        repeat_hint;
  logic [31:0] timestamp_us;

  modport source(output valid, operation, entry_index, entry_code, entry_valid,
                 frame_prefix, frame_key, frame_suffix, repeat_hint, timestamp_us,
                 input ready);
  modport sink(input valid, operation, entry_index, entry_code, entry_valid,
               frame_prefix, frame_key, frame_suffix, repeat_hint, timestamp_us,
               output ready);
endinterface

interface icm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  key_index;
  logic [63:0] full_code;
  logic [15:0] repeat_count;

  modport source(output valid, status, key_index, full_code, repeat_count, input ready);
  modport sink(input valid, status, key_index, full_code, repeat_count, output ready);
endinterface

/* hw/rtl/icm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module icm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* hw/rtl/icm_ctrl.sv */
// Sequencing state machine of the IR frame code matcher.
// Depends on icm_pkg; drives the datapath through icm_pkg::cmd_t.
module icm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_op_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  icm_pkg::stat_t stat_i,
  output icm_pkg::cmd_t  cmd_o
);
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPrep  = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StScan  = 3'd3;
  localparam logic [2:0] StFin   = 3'd4;
  localparam logic [2:0] StRes   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_op_i == icm_pkg::OpLoad) begin
            cmd_o.load = 1'b1;
            state_d    = StRes;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = StPrep;
          end
        end
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        state_d    = StCheck;
      end
      StCheck: begin
        if (stat_i.pre_ok) begin
          cmd_o.scan_start = 1'b1;
          state_d          = StScan;
        end else begin
          state_d = StFin;
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.hit || stat_i.last) begin
          state_d = StFin;
        end
      end
      StFin: begin
        cmd_o.finish = 1'b1;
        state_d      = StRes;
      end
      StRes: begin
        // The result register is free, or its transfer completes this cycle.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
endmodule

/* hw/rtl/icm_dp.sv */
// Datapath of the IR frame code matcher: field checks, key table scan,
// repeat and pairing state, result build. Depends on icm_pkg and icm_ram.
module icm_dp #(
  parameter int unsigned TABLE_DEPTH = icm_pkg::TableDepth,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  icm_pkg::cfg_t  cfg_i,
  input  icm_pkg::cmd_t  cmd_i,
  output icm_pkg::stat_t stat_o,
  input  logic [7:0]     entry_index_i,
  input  logic [63:0]    entry_code_i,
  input  logic           entry_valid_i,
  input  logic [31:0]    frame_prefix_i,
  input  logic [63:0]    frame_key_i,
  input  logic [31:0]    frame_suffix_i,
  input  logic           repeat_hint_i,
  input  logic [31:0]    timestamp_us_i,
  output logic [1:0]     status_o,
  output logic [7:0]     key_index_o,
  output logic [63:0]    full_code_o,
  output logic [15:0]    repeat_count_o
);
  // Captured frame.
  logic [31:0] fpre_q, fsuf_q, ts_q;
  logic [63:0] fkey_q;
  logic        hint_q;

  // Prepared values.
  logic [63:0] code_q, cm_q, kmask_q, base_q;
  logic [7:0]  s_q;
  logic [6:0]  nrev_q;
  logic        tog_q, pre_ok_q;

  // Scan.
  logic [AW-1:0]    ridx_q, cidx_q, slot_q;
  logic             cval_q, used_rd_q, found_q;
  logic [63:0]      key_q, ram_rdata;
  logic [TABLE_DEPTH-1:0] used_q;

  // Persistent match state.
  logic          have_last_q, pss_q, saved_q;
  logic [AW-1:0] last_slot_q, ps_q;
  logic [31:0]   last_time_q;
  logic [15:0]   repeats_q;
  logic [1:0]    phase_q;

  // Result and output registers.
  logic [1:0]  res_status_q, out_status_q;
  logic [7:0]  res_index_q, out_index_q;
  logic [63:0] res_full_q, out_full_q;
  logic [15:0] res_rep_q, out_rep_q;

  logic load_ok;
  logic [AW-1:0] load_addr;
  logic masking;

  assign load_ok   = (32'(entry_index_i) < 32'(TABLE_DEPTH));
  assign load_addr = AW'(entry_index_i);
  assign masking   = (cfg_i.xor_mask != 64'd0);

  icm_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_keys (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load && load_ok),
    .waddr_i(load_addr),
    .wdata_i(entry_code_i),
    .re_i   (cmd_i.scan_step),
    .raddr_i(ridx_q),
    .rdata_o(ram_rdata)
  );

  // Field preparation.
  logic [7:0]  p8, k8, s8, t8, tot8;
  logic [63:0] pmask, kmask, smask, pre_v, code_v, post_v, pv, sv, pm, cm, qm, base_v;
  logic        tog_v, pre_ok_v;

  always_comb begin
    p8 = (cfg_i.pre_bits > 6'd32) ? 8'd32 : 8'(cfg_i.pre_bits);
    s8 = (cfg_i.post_bits > 6'd32) ? 8'd32 : 8'(cfg_i.post_bits);
    k8 = (cfg_i.key_bits == 7'd0) ? 8'd1 :
         ((cfg_i.key_bits > 7'd64) ? 8'd64 : 8'(cfg_i.key_bits));
    tot8  = p8 + k8 + s8;
    t8    = 8'(cfg_i.tog_pos);
    pmask = icm_pkg::low_mask(p8);
    kmask = icm_pkg::low_mask(k8);
    smask = icm_pkg::low_mask(s8);
    pre_v  = {32'd0, fpre_q} & pmask;
    code_v = fkey_q & kmask;
    post_v = {32'd0, fsuf_q} & smask;
    pv     = {32'd0, cfg_i.prefix} & pmask;
    sv     = {32'd0, cfg_i.suffix} & smask;
    pm = '0;
    cm = '0;
    qm = '0;
    tog_v = 1'b0;
    // The toggle bit is counted from the MSB of the whole frame.
    if (t8 != 8'd0) begin
      if (t8 <= p8) begin
        pm    = icm_pkg::shl64(64'd1, p8 - t8);
        tog_v = |(pre_v & pm);
      end else if (t8 <= p8 + k8) begin
        cm    = icm_pkg::shl64(64'd1, p8 + k8 - t8);
        tog_v = |(code_v & cm);
      end else if (t8 <= tot8) begin
        qm    = icm_pkg::shl64(64'd1, tot8 - t8);
        tog_v = |(post_v & qm);
      end
    end
    if (masking && phase_q[0]) begin
      post_v = post_v ^ (cfg_i.xor_mask & smask);
      code_v = code_v ^ (icm_pkg::shr64(cfg_i.xor_mask, s8) & kmask);
      pre_v  = pre_v ^ (icm_pkg::shr64(cfg_i.xor_mask, s8 + k8) & pmask);
    end
    pre_ok_v = ((p8 == 8'd0) || ((pre_v | pm) == (pv | pm))) &&
               ((s8 == 8'd0) || ((post_v | qm) == (sv | qm)));
    base_v = (p8 != 8'd0) ? icm_pkg::shl64(pv, k8) : 64'd0;
    if (s8 != 8'd0) begin
      base_v = icm_pkg::shl64(base_v, s8) | sv;
    end
  end

  // Scan compare on the registered RAM word.
  logic hit;
  assign hit = cval_q && used_rd_q && (((ram_rdata & kmask_q) | cm_q) == (code_q | cm_q));
  assign stat_o.hit    = hit;
  assign stat_o.last   = cval_q && (cidx_q == AW'(TABLE_DEPTH - 1));
  assign stat_o.pre_ok = pre_ok_q;

  // Finish: pairing, repeat tracking and full code.
  logic        pair_bad, found_eff, rep;
  logic [63:0] full0, full_v;
  logic [2:0]  np;
  logic [15:0] rep_inc;

  always_comb begin
    pair_bad  = masking && phase_q[0] && (!pss_q || (ps_q != slot_q));
    found_eff = found_q && !pair_bad;
    rep = have_last_q && (slot_q == last_slot_q) && hint_q &&
          ((ts_q - last_time_q) < icm_pkg::RepeatWindowUs) &&
          ((cfg_i.tog_pos == 7'd0) || (tog_q == saved_q));
    rep_inc = (repeats_q != 16'hFFFF) ? repeats_q + 16'd1 : repeats_q;
    np      = {1'b0, phase_q} + 3'd1;
    full0   = icm_pkg::shl64(key_q & kmask_q, s_q) | base_q;
    full_v  = cfg_i.reverse ?
              icm_pkg::shr64(icm_pkg::bitrev64(full0), 8'(7'd64 - nrev_q)) : full0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      fpre_q <= frame_prefix_i;
      fkey_q <= frame_key_i;
      fsuf_q <= frame_suffix_i;
      hint_q <= repeat_hint_i;
      ts_q   <= timestamp_us_i;
    end
    if (cmd_i.prep) begin
      code_q   <= code_v;
      cm_q     <= cm;
      kmask_q  <= kmask;
      base_q   <= base_v;
      s_q      <= s8;
      nrev_q   <= (tot8 > 8'd64) ? 7'd64 : 7'(tot8);
      tog_q    <= tog_v;
      pre_ok_q <= pre_ok_v;
    end
    if (cmd_i.scan_step) begin
      cidx_q    <= ridx_q;
      used_rd_q <= used_q[ridx_q];
      if (hit) begin
        slot_q <= cidx_q;
        key_q  <= ram_rdata;
      end
    end
    if (cmd_i.load) begin
      res_status_q <= icm_pkg::StatusLoad;
      res_index_q  <= '0;
      res_full_q   <= '0;
      res_rep_q    <= '0;
    end
    if (cmd_i.finish) begin
      if (!found_eff) begin
        res_status_q <= icm_pkg::StatusMiss;
        res_index_q  <= '0;
        res_full_q   <= '0;
        res_rep_q    <= '0;
      end else begin
        res_index_q <= 8'(slot_q);
        res_full_q  <= full_v;
        if (rep) begin
          res_rep_q <= (masking && np >= icm_pkg::PhaseWrap) ? rep_inc :
                       (masking ? repeats_q : rep_inc);
          res_status_q <= (masking && np[0] && np < icm_pkg::PhaseWrap) ?
                          icm_pkg::StatusHeld : icm_pkg::StatusKey;
        end else begin
          res_rep_q    <= '0;
          res_status_q <= masking ? icm_pkg::StatusHeld : icm_pkg::StatusKey;
        end
      end
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
      out_full_q   <= res_full_q;
      out_rep_q    <= res_rep_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      ridx_q      <= '0;
      cval_q      <= 1'b0;
      found_q     <= 1'b0;
      have_last_q <= 1'b0;
      last_slot_q <= '0;
      last_time_q <= '0;
      repeats_q   <= '0;
      phase_q     <= '0;
      ps_q        <= '0;
      pss_q       <= 1'b0;
      saved_q     <= 1'b0;
    end else begin
      if (cmd_i.load && load_ok) begin
        used_q[load_addr] <= entry_valid_i;
      end
      if (cmd_i.capture) begin
        found_q <= 1'b0;
      end
      if (cmd_i.scan_start) begin
        ridx_q <= '0;
        cval_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        cval_q <= 1'b1;
        if (ridx_q != AW'(TABLE_DEPTH - 1)) begin
          ridx_q <= ridx_q + AW'(1);
        end
        if (hit) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        // Even-phase hits store the pairing slot; odd-phase hits clear it.
        if (found_q && masking) begin
          if (!phase_q[0]) begin
            ps_q  <= slot_q;
            pss_q <= 1'b1;
          end else begin
            pss_q <= 1'b0;
          end
        end
        if (!found_eff) begin
          phase_q     <= '0;
          have_last_q <= 1'b0;
        end else begin
          if (rep) begin
            if (masking) begin
              if (np >= icm_pkg::PhaseWrap) begin
                repeats_q <= rep_inc;
                phase_q   <= icm_pkg::PhaseRestart;
              end else begin
                phase_q <= np[1:0];
              end
            end else begin
              repeats_q <= rep_inc;
            end
          end else begin
            repeats_q   <= '0;
            last_slot_q <= slot_q;
            if (masking) begin
              phase_q <= 2'd1;
              ps_q    <= slot_q;
              pss_q   <= 1'b1;
            end
            if (cfg_i.tog_pos != 7'd0) begin
              saved_q <= tog_q;
            end
          end
          have_last_q <= 1'b1;
          last_time_q <= ts_q;
        end
      end
    end
  end

  assign status_o       = out_status_q;
  assign key_index_o    = out_index_q;
  assign full_code_o    = out_full_q;
  assign repeat_count_o = out_rep_q;
endmodule

/* hw/rtl/ir_frame_code_matcher.sv */
// Top level of the IR frame code matcher: configuration registers, controller
// and datapath. Depends on icm_pkg, icm_if, icm_ctrl, icm_dp and icm_ram.

// A load item goes from the input straight to the result state. A decode item passes
// through the prepare, check, scan and finish states; its scan ends early when a slot
// matches, and is skipped when the prefix/suffix check fails. The key table scan reads
// one slot per cycle from the key RAM, which has one write and one read port. One item
// is in work at a time; a finished result waits in the output register while
// the next item is taken in.
module ir_frame_code_matcher #(
  parameter int unsigned TABLE_DEPTH = icm_pkg::TableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  icm_in_if.sink      in_chan_i,
  icm_out_if.source   out_chan_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  icm_pkg::cfg_t  cfg_q;
  icm_pkg::cmd_t  cmd;
  icm_pkg::stat_t stat;
  logic [2:0]     reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{key_bits: 7'd32, default: '0};
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        icm_pkg::RegPreBits:  cfg_q.pre_bits  <= pwdata[5:0];
        icm_pkg::RegKeyBits:  cfg_q.key_bits  <= pwdata[6:0];
        icm_pkg::RegPostBits: cfg_q.post_bits <= pwdata[5:0];
        icm_pkg::RegPrefix:   cfg_q.prefix    <= pwdata[31:0];
        icm_pkg::RegSuffix:   cfg_q.suffix    <= pwdata[31:0];
        icm_pkg::RegTogPos:   cfg_q.tog_pos   <= pwdata[6:0];
        icm_pkg::RegXorMask:  cfg_q.xor_mask  <= pwdata;
        icm_pkg::RegReverse:  cfg_q.reverse   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      icm_pkg::RegPreBits:  prdata = 64'(cfg_q.pre_bits);
      icm_pkg::RegKeyBits:  prdata = 64'(cfg_q.key_bits);
      icm_pkg::RegPostBits: prdata = 64'(cfg_q.post_bits);
      icm_pkg::RegPrefix:   prdata = 64'(cfg_q.prefix);
      icm_pkg::RegSuffix:   prdata = 64'(cfg_q.suffix);
      icm_pkg::RegTogPos:   prdata = 64'(cfg_q.tog_pos);
      icm_pkg::RegXorMask:  prdata = cfg_q.xor_mask;
      icm_pkg::RegReverse:  prdata = 64'(cfg_q.reverse);
      default:              prdata = '0;
    endcase
  end

  icm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan_i.valid),
    .in_op_i    (in_chan_i.operation),
    .in_ready_o (in_chan_i.ready),
    .out_valid_o(out_chan_o.valid),
    .out_ready_i(out_chan_o.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  icm_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .entry_index_i (in_chan_i.entry_index),
    .entry_code_i  (in_chan_i.entry_code),
    .entry_valid_i (in_chan_i.entry_valid),
    .frame_prefix_i(in_chan_i.frame_prefix),
    .frame_key_i   (in_chan_i.frame_key),
    .frame_suffix_i(in_chan_i.frame_suffix),
    .repeat_hint_i (in_chan_i.repeat_hint),
    .timestamp_us_i(in_chan_i.timestamp_us),
    .status_o      (out_chan_o.status),
    .key_index_o   (out_chan_o.key_index),
    .full_code_o   (out_chan_o.full_code),
    .repeat_count_o(out_chan_o.repeat_count)
  );

  // One item at a time: a transfer in closes the input until the item is done.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_chan_i.valid && in_chan_i.ready |=> !in_chan_i.ready)
    else $error("input taken while an item is in work");

  a_no_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan_o.valid && (cfg_q.xor_mask == 64'd0) |-> out_chan_o.status != icm_pkg::StatusHeld)
    else $error("pair hold reported with pairing disabled");

  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan_o.valid && (out_chan_o.status == icm_pkg::StatusLoad ||
                         out_chan_o.status == icm_pkg::StatusMiss)
    |-> out_chan_o.full_code == 64'd0 && out_chan_o.repeat_count == 16'd0 &&
        out_chan_o.key_index == 8'd0)
    else $error("load or miss result carries nonzero fields");
endmodule

/* tb/sv/tb_ir_frame_code_matcher.sv */
// Self-checking testbench of the IR frame code matcher: random valid/ready traffic,
// APB register setup and a behavioral predictor of the key table and repeat logic.
// Depends on icm_pkg, icm_if and the ir_frame_code_matcher RTL.
`timescale 1ns / 100ps

module tb_ir_frame_code_matcher;

  localparam int unsigned Depth = 256;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned SettleCycles = 300;

  typedef struct {
    bit        op;
    bit [7:0]  idx;
    bit [63:0] code;
    bit        ev;
    bit [31:0] pre;
    bit [63:0] key;
    bit [31:0] post;
    bit        rep;
    bit [31:0] ts;
  } frame_t;

  typedef struct {
    bit [1:0]  status;
    bit [7:0]  slot;
    bit [63:0] full;
    bit [15:0] count;
  } match_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  icm_in_if  in_if ();
  icm_out_if out_if ();

  ir_frame_code_matcher u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if),
    .out_chan_o (out_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Register copies used by the predictor.
  bit [5:0]  cfg_pre = 6'd0;
  bit [6:0]  cfg_key = 7'd32;
  bit [5:0]  cfg_post = 6'd0;
  bit [31:0] cfg_prefix = '0;
  bit [31:0] cfg_suffix = '0;
  bit [6:0]  cfg_tog = '0;
  bit [63:0] cfg_mask = '0;
  bit        cfg_rev = 1'b0;

  // Predictor state.
  bit [63:0]   key_mem [Depth];
  bit          key_used [Depth];
  bit          rp_have;
  int unsigned rp_slot;
  bit [31:0]   rp_time;
  int unsigned rp_count;
  int unsigned pr_phase;
  int unsigned pr_slot;
  bit          pr_set;
  bit          rp_tog;

  // Generator's view of the table, updated as items are queued.
  bit [63:0] gen_key [Depth];
  bit        gen_used [Depth];
  bit [31:0] gen_ts;

  frame_t frames_to_send [$];
  match_t awaited_matches [$];
  int unsigned n_queued, n_taken, n_results, n_errors, n_settings;
  int unsigned src_idle, snk_idle;
  bit in_took;
  bit hold_req;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  function automatic bit [63:0] ones(int unsigned n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic bit [63:0] rsh(bit [63:0] x, int unsigned n);
    return (n >= 64) ? 64'd0 : (x >> n);
  endfunction

  function automatic bit [63:0] lsh(bit [63:0] x, int unsigned n);
    return (n >= 64) ? 64'd0 : (x << n);
  endfunction

  function automatic void eff_widths(output int unsigned p, output int unsigned k,
                                     output int unsigned s);
    p = (cfg_pre > 32) ? 32 : cfg_pre;
    s = (cfg_post > 32) ? 32 : cfg_post;
    k = (cfg_key == 0) ? 1 : ((cfg_key > 64) ? 64 : cfg_key);
  endfunction

  function automatic match_t predict_match(frame_t f);
    int unsigned p, k, s, t, total, slot, n;
    bit [63:0] pre, code, post, pm, cm, qm, pv, sv, full, rev;
    bit tog, found, masking;
    match_t r;
    r = '{default: '0};
    pm = '0; cm = '0; qm = '0; tog = 0; found = 0; slot = 0;
    if (f.op == icm_pkg::OpLoad) begin
      key_mem[f.idx] = f.code;
      key_used[f.idx] = f.ev;
      r.status = icm_pkg::StatusLoad;
      return r;
    end
    eff_widths(p, k, s);
    total = p + k + s;
    t = cfg_tog;
    masking = (cfg_mask != 0);
    pre = 64'(f.pre) & ones(p);
    code = f.key & ones(k);
    post = 64'(f.post) & ones(s);
    pv = 64'(cfg_prefix) & ones(p);
    sv = 64'(cfg_suffix) & ones(s);
    if (t > 0) begin
      if (t <= p) begin
        pm = 64'd1 << (p - t);
        tog = (pre & pm) != 0;
      end else if (t <= p + k) begin
        cm = 64'd1 << (p + k - t);
        tog = (code & cm) != 0;
      end else if (t <= total) begin
        qm = 64'd1 << (total - t);
        tog = (post & qm) != 0;
      end
    end
    // Odd pair phases expect the frame with the mask bits inverted.
    if (masking && pr_phase[0]) begin
      post ^= cfg_mask & ones(s);
      code ^= rsh(cfg_mask, s) & ones(k);
      pre ^= rsh(cfg_mask, s + k) & ones(p);
    end
    if ((p == 0 || (pre | pm) == (pv | pm)) && (s == 0 || (post | qm) == (sv | qm))) begin
      for (int i = 0; i < Depth; i++) begin
        if (key_used[i] && (((key_mem[i] & ones(k)) | cm) == (code | cm))) begin
          found = 1;
          slot = i;
          if (masking) begin
            if (!pr_phase[0]) begin
              pr_slot = i;
              pr_set = 1;
            end else begin
              if (!pr_set || pr_slot != i) found = 0;
              pr_set = 0;
            end
          end
          break;
        end
      end
    end
    if (!found) begin
      pr_phase = 0;
      rp_have = 0;
      r.status = icm_pkg::StatusMiss;
      return r;
    end
    if (rp_have && slot == rp_slot && f.rep && (f.ts - rp_time) < 32'd1000000 &&
        (t == 0 || tog == rp_tog)) begin
      if (masking) begin
        pr_phase++;
        if (pr_phase >= 4) begin
          if (rp_count < 65535) rp_count++;
          pr_phase = 2;
        end
      end else if (rp_count < 65535) begin
        rp_count++;
      end
    end else begin
      rp_count = 0;
      rp_slot = slot;
      if (masking) begin
        pr_phase = 1;
        pr_slot = slot;
        pr_set = 1;
      end
      if (t > 0) rp_tog = tog;
    end
    rp_have = 1;
    rp_time = f.ts;
    full = (p > 0) ? lsh(pv, k) : 64'd0;
    full |= key_mem[rp_slot] & ones(k);
    if (s > 0) full = lsh(full, s) | sv;
    if (cfg_rev) begin
      n = (total > 64) ? 64 : total;
      rev = '0;
      for (int i = 0; i < n; i++) begin
        rev = (rev << 1) | 64'(full[0]);
        full >>= 1;
      end
      full = rev;
    end
    r.status = (masking && pr_phase[0]) ? icm_pkg::StatusHeld : icm_pkg::StatusKey;
    r.slot = rp_slot[7:0];
    r.full = full;
    r.count = rp_count[15:0];
    return r;
  endfunction

  // Input driver: a held item stays on the bus until its transfer.
  always @(negedge clk_i) begin
    frame_t f;
    if (rst_ni && (!in_if.valid || in_took)) begin
      if (frames_to_send.size() > 0 && $urandom_range(99) >= src_idle) begin
        f = frames_to_send.pop_front();
        in_if.operation    <= f.op;
        in_if.entry_index  <= f.idx;
        in_if.entry_code   <= f.code;
        in_if.entry_valid  <= f.ev;
        in_if.frame_prefix <= f.pre;
        in_if.frame_key    <= f.key;
        in_if.frame_suffix <= f.post;
        in_if.repeat_hint  <= f.rep;
        in_if.timestamp_us <= f.ts;
        in_if.valid        <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver, with a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 2000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rst_ni && ($urandom_range(99) >= snk_idle);
    end
  end

  // Monitor: predict on input transfers, check on output transfers.
  always @(posedge clk_i) begin
    frame_t f;
    match_t want;
    in_took = in_if.valid && in_if.ready;
    if (in_took) begin
      f.op = in_if.operation;
      f.idx = in_if.entry_index;
      f.code = in_if.entry_code;
      f.ev = in_if.entry_valid;
      f.pre = in_if.frame_prefix;
      f.key = in_if.frame_key;
      f.post = in_if.frame_suffix;
      f.rep = in_if.repeat_hint;
      f.ts = in_if.timestamp_us;
      awaited_matches.push_back(predict_match(f));
      n_taken++;
    end
    if (out_if.valid && out_if.ready) begin
      n_results++;
      if (awaited_matches.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result status=%0d slot=%0d code=%h count=%0d", $time,
                 out_if.status, out_if.key_index, out_if.full_code, out_if.repeat_count);
      end else begin
        want = awaited_matches.pop_front();
        if (out_if.status !== want.status || out_if.key_index !== want.slot ||
            out_if.full_code !== want.full || out_if.repeat_count !== want.count) begin
          n_errors++;
          $display("%0t: mismatch expected status=%0d slot=%0d code=%h count=%0d", $time,
                   want.status, want.slot, want.full, want.count);
          $display("%0t:          actual   status=%0d slot=%0d code=%h count=%0d", $time,
                   out_if.status, out_if.key_index, out_if.full_code, out_if.repeat_count);
        end
      end
    end
    if (in_took || (out_if.valid && out_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Timeout: no transfer for %0d cycles", StallLimit);
      $display("** ir_frame_code_matcher: FAILED **");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      icm_pkg::RegPreBits:  cfg_pre = val[5:0];
      icm_pkg::RegKeyBits:  cfg_key = val[6:0];
      icm_pkg::RegPostBits: cfg_post = val[5:0];
      icm_pkg::RegPrefix:   cfg_prefix = val[31:0];
      icm_pkg::RegSuffix:   cfg_suffix = val[31:0];
      icm_pkg::RegTogPos:   cfg_tog = val[6:0];
      icm_pkg::RegXorMask:  cfg_mask = val;
      icm_pkg::RegReverse:  cfg_rev = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned pb, input int unsigned kb, input int unsigned sb,
                           input int unsigned tp, input logic [63:0] mask, input bit rev);
    reg_write(icm_pkg::RegPreBits, 64'(pb));
    reg_write(icm_pkg::RegKeyBits, 64'(kb));
    reg_write(icm_pkg::RegPostBits, 64'(sb));
    reg_write(icm_pkg::RegPrefix, {32'd0, $urandom});
    reg_write(icm_pkg::RegSuffix, {32'd0, $urandom});
    reg_write(icm_pkg::RegTogPos, 64'(tp));
    reg_write(icm_pkg::RegXorMask, mask);
    reg_write(icm_pkg::RegReverse, 64'(rev));
    n_settings++;
  endtask

  // Waits until every queued item has been taken and every result has come back.
  task automatic drain();
    while (n_taken != n_queued || awaited_matches.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic queue_item(input frame_t f);
    if (f.op == icm_pkg::OpLoad) begin
      gen_key[f.idx] = f.code;
      gen_used[f.idx] = f.ev;
    end
    frames_to_send.push_back(f);
    n_queued++;
  endtask

  task automatic queue_load(input int unsigned idx, input bit [63:0] code, input bit ev);
    frame_t f;
    f = '{default: '0};
    f.op = icm_pkg::OpLoad;
    f.idx = idx[7:0];
    f.code = code;
    f.ev = ev;
    f.pre = $urandom;
    f.ts = $urandom;
    queue_item(f);
  endtask

  // A well-formed frame for a key, with random bits above each field's width.
  task automatic queue_frame(input bit [63:0] key, input bit rep, input bit xored,
                             input bit flip, input bit [31:0] ts);
    frame_t f;
    int unsigned p, k, s, t;
    eff_widths(p, k, s);
    t = cfg_tog;
    f.op = icm_pkg::OpDecode;
    f.idx = 8'($urandom);
    f.code = {$urandom, $urandom};
    f.ev = 1'($urandom);
    f.pre = 32'((64'(cfg_prefix) & ones(p)) | (64'($urandom) & ~ones(p)));
    f.key = (key & ones(k)) | ({$urandom, $urandom} & ~ones(k));
    f.post = 32'((64'(cfg_suffix) & ones(s)) | (64'($urandom) & ~ones(s)));
    f.rep = rep;
    f.ts = ts;
    if (xored) begin
      f.post ^= 32'(cfg_mask & ones(s));
      f.key ^= rsh(cfg_mask, s) & ones(k);
      f.pre ^= 32'(rsh(cfg_mask, s + k) & ones(p));
    end
    if (flip && t > 0) begin
      if (t <= p) f.pre ^= 32'(64'd1 << (p - t));
      else if (t <= p + k) f.key ^= 64'd1 << (p + k - t);
      else if (t <= p + k + s) f.post ^= 32'(64'd1 << (p + k + s - t));
    end
    queue_item(f);
  endtask

  task automatic queue_noise();
    frame_t f;
    f.op = icm_pkg::OpDecode;
    f.idx = 8'($urandom);
    f.code = {$urandom, $urandom};
    f.ev = 1'($urandom);
    f.pre = $urandom;
    f.key = {$urandom, $urandom};
    f.post = $urandom;
    f.rep = 1'($urandom);
    f.ts = $urandom;
    queue_item(f);
  endtask

  task automatic fill_table();
    for (int i = 0; i < 16; i++) queue_load(i, {$urandom, $urandom}, $urandom_range(5) != 0);
    // A duplicate key further down checks that the first slot wins.
    queue_load(12, gen_key[3], 1'b1);
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned cnt, slot, len, roll;
    bit flip, broken;
    cnt = 0;
    while (cnt < n) begin
      roll = $urandom_range(99);
      slot = $urandom_range(Depth - 1);
      if (roll >= 20) begin
        for (int i = 0; i < Depth && !gen_used[slot]; i++) slot = (slot + 1) % Depth;
      end
      if (roll < 8) begin
        queue_load(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(31),
                   {$urandom, $urandom}, $urandom_range(4) != 0);
        cnt++;
      end else if (roll < 20 || !gen_used[slot]) begin
        queue_noise();
        cnt++;
      end else begin
        len = $urandom_range(1, 8);
        flip = 1'($urandom);
        gen_ts += $urandom_range(1000, 3000000);
        for (int j = 0; j < len; j++) begin
          broken = ($urandom_range(19) == 0);
          if (j > 0) gen_ts += ($urandom_range(15) == 0) ? $urandom_range(900000, 1100000)
                                                          : $urandom_range(50, 150000);
          queue_frame(gen_key[slot], (j == 0) ? bit'($urandom) : ($urandom_range(9) != 0),
                      (cfg_mask != 0) && (j[0] ^ broken), flip ^ ($urandom_range(9) == 0),
                      gen_ts);
        end
        cnt += len;
      end
    end
  endtask

  initial begin
    bit [63:0] k0;
    in_if.valid = 1'b0;
    in_if.operation = 1'b0;
    in_if.entry_index = '0;
    in_if.entry_code = '0;
    in_if.entry_valid = 1'b0;
    in_if.frame_prefix = '0;
    in_if.frame_key = '0;
    in_if.frame_suffix = '0;
    in_if.repeat_hint = 1'b0;
    in_if.timestamp_us = '0;
    out_if.ready = 1'b0;
    gen_ts = 32'hFFF0_0000;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    src_idle = 30;
    snk_idle = 47;

    // Directed part: table corners, first hit, window edges and timestamp wrap.
    configure(16, 32, 8, 0, 64'd0, 1'b0);
    k0 = {$urandom, $urandom};
    queue_load(0, k0, 1'b1);
    queue_load(255, '1, 1'b1);
    queue_load(1, 64'd0, 1'b1);
    queue_load(2, k0, 1'b1);
    queue_load(3, 64'h5A5A_1234, 1'b1);
    queue_load(3, 64'h5A5A_1234, 1'b0);
    queue_frame(k0, 1'b0, 1'b0, 1'b0, 32'd1000);
    queue_frame(k0, 1'b1, 1'b0, 1'b0, 32'd2000);
    queue_frame(k0, 1'b1, 1'b0, 1'b0, 32'd1001999);
    queue_frame(k0, 1'b1, 1'b0, 1'b0, 32'd2001999);
    queue_frame(k0, 1'b0, 1'b0, 1'b0, 32'd2002000);
    queue_frame('1, 1'b0, 1'b0, 1'b0, 32'd5000000);
    queue_frame(64'd0, 1'b1, 1'b0, 1'b0, 32'd5000100);
    queue_frame(64'h5A5A_1234, 1'b1, 1'b0, 1'b0, 32'd5000200);
    queue_frame(k0, 1'b1, 1'b0, 1'b0, 32'hFFFF_FF00);
    queue_frame(k0, 1'b1, 1'b0, 1'b0, 32'h0000_0100);
    frames_to_send[$].pre ^= 32'h1;
    queue_frame(k0, 1'b1, 1'b0, 1'b0, 32'h0000_0200);
    frames_to_send[$].post ^= 32'h80;
    queue_noise();
    drain();

    // Full prefix, toggle bit in the prefix, reversed output.
    configure(32, 32, 0, 5, 64'd0, 1'b1);
    fill_table();
    random_traffic(160);
    drain();

    // Toggle-mask pairing with a toggle bit in the key; the receiver stalls long.
    src_idle = 47;
    snk_idle = 30;
    configure(8, 16, 8, 20, {$urandom, $urandom} | 64'h1, 1'b0);
    fill_table();
    random_traffic(170);
    hold_req = 1;
    drain();

    // Wide frame that overflows 64 bits, all-ones mask, toggle bit in the suffix.
    configure(32, 64, 32, 127, '1, 1'b1);
    fill_table();
    random_traffic(160);
    drain();

    src_idle = 0;
    snk_idle = 0;
    // No prefix or suffix, zero key width.
    configure(0, 0, 0, 1, 64'd0, 1'b0);
    fill_table();
    random_traffic(160);
    drain();

    // Out-of-range prefix, key and suffix widths.
    configure(63, 127, 63, 100, 64'd1, 1'b1);
    fill_table();
    random_traffic(160);
    drain();

    // An unbroken run of repeats of one key counts up step by step.
    configure(0, 8, 0, 0, 64'd0, 1'b0);
    queue_load(0, 64'h42, 1'b1);
    for (int i = 0; i < 40; i++) begin
      gen_ts += 1000;
      queue_frame(64'h42, 1'b1, 1'b0, 1'b0, gen_ts);
    end
    drain();

    $display("Run covered %0d items and %0d results over %0d register settings,", n_taken,
             n_results, n_settings);
    $display("including toggle-mask pairing, wide frames, odd widths and long repeat runs.");
    if (n_errors == 0) begin
      $display("** ir_frame_code_matcher: PASSED **");
    end else begin
      $display("** ir_frame_code_matcher: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/icm_pkg.sv
hw/rtl/icm_if.sv
hw/rtl/icm_ram.sv
hw/rtl/icm_ctrl.sv
hw/rtl/icm_dp.sv
hw/rtl/ir_frame_code_matcher.sv
tb/sv/tb_ir_frame_code_matcher.sv
